// File: design/mep_pkg.sv
// Package with the shared types, widths and constants of the escape-time pixel evaluator.
`default_nettype none
package mep_pkg;

    localparam int COL_W       = 12;
    localparam int ROW_W       = 12;
    localparam int ORIGIN_W    = 27;
    localparam int STEP_W      = 23;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 27;
    localparam int ITER_W      = 9;
    localparam int HUE_W       = 8;

    // Product of a coordinate and a step, and the point c formed from it.
    localparam int C_PROD_W    = COL_W + 1 + STEP_W;
    localparam int C_W         = C_PROD_W + 1;

    localparam int DEF_MAX_ITER  = 256;
    localparam int DEF_FRAC_BITS = 24;

    // The escape radius squared is 1000000, so the radius is below 2^10.
    localparam int ESCAPE_LIMIT  = 1000000;
    localparam int ESC_ROOT_BITS = 10;
    localparam int HUE_BASE      = 'h120;

    localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP   = 4'd3;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } pixel_item_t;

    typedef struct packed {
        logic [ITER_W-1:0] iterations;
        logic              inside_res;
        logic [HUE_W-1:0]  hue;
    } result_item_t;

    typedef struct packed {
        logic load_pixel;
        logic coord_mul;
        logic form_c;
        logic take_abs;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic step;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic escape;
        logic last;
    } dp_status_t;

endpackage
`default_nettype wire

// File: design/mep_ctrl.sv
// Controller state machine that sequences the set-up, iteration and result hand-over.
`default_nettype none
module mep_ctrl
    import mep_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pixel_valid,
    output logic            pixel_ready,
    output logic            result_valid,
    input  wire logic       result_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_COORD  = 4'd1;
    localparam logic [3:0] S_FORM   = 4'd2;
    localparam logic [3:0] S_ABS    = 4'd3;
    localparam logic [3:0] S_MUL_LO = 4'd4;
    localparam logic [3:0] S_MUL_HI = 4'd5;
    localparam logic [3:0] S_ACC    = 4'd6;
    localparam logic [3:0] S_TEST   = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;
    logic       slot_free;

    assign pixel_ready  = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign slot_free    = !result_valid_reg || result_ready;

    always_comb
    begin
        cmd               = '0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = S_COORD;
                end
            end
            S_COORD:
            begin
                cmd.coord_mul = 1'b1;
                state_next    = S_FORM;
            end
            S_FORM:
            begin
                cmd.form_c = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.take_abs = 1'b1;
                state_next   = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (status.escape)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = status.last ? S_FINISH : S_ABS;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_result   = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready) |=> (state_reg == S_COORD))
        else $error("accepted item did not start set-up");

    a_escape_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST && status.escape) |=> (state_reg == S_FINISH))
        else $error("escape did not end the iteration");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !result_valid_reg) |=>
        (state_reg == S_IDLE && result_valid_reg))
        else $error("free result slot was not filled");

endmodule
`default_nettype wire

// File: design/mep_dp.sv
// Datapath with the configuration registers, the point c and the shared iteration unit.
`default_nettype none
module mep_dp
    import mep_pkg::*;
#(
    parameter int MAX_ITER  = DEF_MAX_ITER,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire pixel_item_t           pixel,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 status,
    output result_item_t               result
);

    localparam int MAG_W  = FRAC_BITS + ESC_ROOT_BITS;
    localparam int HALF_W = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - HALF_W;
    localparam int LO_P_W = MAG_W + HALF_W;
    localparam int HI_P_W = MAG_W + HI_W;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = PROD_W - FRAC_BITS;
    localparam int Z_W    = (FRAC_BITS + 22 > C_W + 1) ? FRAC_BITS + 22 : C_W + 1;
    localparam int CNT_W  = $clog2(MAX_ITER + 1);
    localparam logic [SQ_W:0] ESC_THRESH = (SQ_W + 1)'(ESCAPE_LIMIT) << FRAC_BITS;

    logic signed [ORIGIN_W-1:0] real_origin_reg;
    logic signed [ORIGIN_W-1:0] imag_origin_reg;
    logic signed [STEP_W-1:0]   real_step_reg;
    logic signed [STEP_W-1:0]   imag_step_reg;

    logic [COL_W-1:0]           col_reg;
    logic [ROW_W-1:0]           row_reg;
    logic signed [COL_W:0]      col_s;
    logic signed [ROW_W:0]      row_s;
    logic signed [C_PROD_W-1:0] c_prod_re_reg;
    logic signed [C_PROD_W-1:0] c_prod_im_reg;
    logic signed [C_W-1:0]      c_re_reg;
    logic signed [C_W-1:0]      c_im_reg;

    logic signed [Z_W-1:0]      zr_reg;
    logic signed [Z_W-1:0]      zi_reg;
    logic signed [Z_W-1:0]      zr_next;
    logic signed [Z_W-1:0]      zi_next;
    logic [Z_W-1:0]             abs_r;
    logic [Z_W-1:0]             abs_i;
    logic [MAG_W-1:0]           mag_r_reg;
    logic [MAG_W-1:0]           mag_i_reg;
    logic                       neg_reg;

    logic [LO_P_W-1:0]          lo_rr_reg;
    logic [LO_P_W-1:0]          lo_ii_reg;
    logic [LO_P_W-1:0]          lo_ri_reg;
    logic [HI_P_W-1:0]          hi_rr_reg;
    logic [HI_P_W-1:0]          hi_ii_reg;
    logic [HI_P_W-1:0]          hi_ri_reg;
    logic [PROD_W-1:0]          full_rr_reg;
    logic [PROD_W-1:0]          full_ii_reg;
    logic [PROD_W-1:0]          full_ri_reg;

    logic [SQ_W-1:0]            sq_r;
    logic [SQ_W-1:0]            sq_i;
    logic [SQ_W-1:0]            cross_mag;
    logic                       cross_rem;
    logic [SQ_W:0]              sq_sum;
    logic [Z_W-1:0]             cross_ext;
    logic [Z_W-1:0]             cross_val;

    logic [CNT_W-1:0]           count_reg;
    logic                       at_limit;
    result_item_t               result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg <= '0;
            imag_origin_reg <= '0;
            real_step_reg   <= '0;
            imag_step_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_REAL_ORIGIN: real_origin_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_IMAG_ORIGIN: imag_origin_reg <= cfg_data[ORIGIN_W-1:0];
                CFG_REAL_STEP:   real_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_IMAG_STEP:   imag_step_reg   <= cfg_data[STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign col_s = {1'b0, col_reg};
    assign row_s = {1'b0, row_reg};

    assign abs_r = zr_reg[Z_W-1] ? Z_W'(-zr_reg) : Z_W'(zr_reg);
    assign abs_i = zi_reg[Z_W-1] ? Z_W'(-zi_reg) : Z_W'(zi_reg);

    assign sq_r      = full_rr_reg[PROD_W-1:FRAC_BITS];
    assign sq_i      = full_ii_reg[PROD_W-1:FRAC_BITS];
    assign cross_mag = full_ri_reg[PROD_W-1:FRAC_BITS];
    assign cross_rem = |full_ri_reg[FRAC_BITS-1:0];
    assign sq_sum    = (SQ_W + 1)'(sq_r) + (SQ_W + 1)'(sq_i);

    // A negative cross product rounds toward minus infinity: -(m + rem) = ~m + !rem.
    assign cross_ext = Z_W'(cross_mag);
    assign cross_val = neg_reg ? (~cross_ext + Z_W'(!cross_rem)) : cross_ext;

    assign zr_next = Z_W'(sq_r) - Z_W'(sq_i) + Z_W'(c_re_reg);
    assign zi_next = {cross_val[Z_W-2:0], 1'b0} + Z_W'(c_im_reg);

    assign status.escape = (sq_sum >= ESC_THRESH);
    assign status.last   = (count_reg == CNT_W'(MAX_ITER - 1));

    assign at_limit = (count_reg == CNT_W'(MAX_ITER));

    assign result = result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            col_reg <= pixel.column;
            row_reg <= pixel.row;
        end
        if (cmd.coord_mul)
        begin
            c_prod_re_reg <= col_s * real_step_reg;
            c_prod_im_reg <= row_s * imag_step_reg;
        end
        if (cmd.form_c)
        begin
            c_re_reg  <= C_W'(real_origin_reg) + C_W'(c_prod_re_reg);
            c_im_reg  <= C_W'(imag_origin_reg) + C_W'(c_prod_im_reg);
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        // Magnitudes of 2^10 or more are clamped; they escape all the same.
        if (cmd.take_abs)
        begin
            mag_r_reg <= (|abs_r[Z_W-1:MAG_W]) ? '1 : abs_r[MAG_W-1:0];
            mag_i_reg <= (|abs_i[Z_W-1:MAG_W]) ? '1 : abs_i[MAG_W-1:0];
            neg_reg   <= zr_reg[Z_W-1] ^ zi_reg[Z_W-1];
        end
        if (cmd.mul_lo)
        begin
            lo_rr_reg <= LO_P_W'(mag_r_reg) * LO_P_W'(mag_r_reg[HALF_W-1:0]);
            lo_ii_reg <= LO_P_W'(mag_i_reg) * LO_P_W'(mag_i_reg[HALF_W-1:0]);
            lo_ri_reg <= LO_P_W'(mag_r_reg) * LO_P_W'(mag_i_reg[HALF_W-1:0]);
        end
        if (cmd.mul_hi)
        begin
            hi_rr_reg <= HI_P_W'(mag_r_reg) * HI_P_W'(mag_r_reg[MAG_W-1:HALF_W]);
            hi_ii_reg <= HI_P_W'(mag_i_reg) * HI_P_W'(mag_i_reg[MAG_W-1:HALF_W]);
            hi_ri_reg <= HI_P_W'(mag_r_reg) * HI_P_W'(mag_i_reg[MAG_W-1:HALF_W]);
        end
        if (cmd.acc)
        begin
            full_rr_reg <= PROD_W'(lo_rr_reg) + (PROD_W'(hi_rr_reg) << HALF_W);
            full_ii_reg <= PROD_W'(lo_ii_reg) + (PROD_W'(hi_ii_reg) << HALF_W);
            full_ri_reg <= PROD_W'(lo_ri_reg) + (PROD_W'(hi_ri_reg) << HALF_W);
        end
        if (cmd.step)
        begin
            zr_reg    <= zr_next;
            zi_reg    <= zi_next;
            count_reg <= CNT_W'(count_reg + 1'b1);
        end
        if (cmd.load_result)
        begin
            result_reg.iterations <= ITER_W'(count_reg);
            result_reg.inside_res <= at_limit;
            result_reg.hue        <= at_limit ? '0 : (HUE_W'(HUE_BASE) - HUE_W'(count_reg));
        end
    end

endmodule
`default_nettype wire

// File: design/mandelbrot_escape_time_pixel_top.sv
// Top level of the escape-time pixel evaluator: controller, datapath and ports.
// Each pixel item maps to c = origin + coordinate * step in signed fixed point and
// iterates z = z*z + c from zero until |z|^2 reaches 1000000 or MAX_ITER iterations
// have run. The block works on one item at a time and accepts the next item only once
// the result of the last one has been loaded into the output register. Each iteration
// runs through the iteration unit in order: it takes the magnitudes, then makes two
// half-width passes in which three multipliers form each square and the cross product,
// then an accumulate and a test. A finished result waits in the output register while
// the next item is accepted. The configuration port is always ready and should only
// be written while no item is in flight; writes to unknown indexes are ignored.
`default_nettype none
module mandelbrot_escape_time_pixel_top
    import mep_pkg::*;
#(
    parameter int MAX_ITER  = DEF_MAX_ITER,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  pixel_valid,
    output logic                       pixel_ready,
    input  wire pixel_item_t           pixel,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_item_t               result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    mep_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mep_dp #(
        .MAX_ITER  (MAX_ITER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
`default_nettype wire
